>>> design/piq_pkg.sv
// Shared types and widths for the point-in-quadrilateral test.
`default_nettype none
package piq_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int NUM_EDGES = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

endpackage
`default_nettype wire

>>> design/point_in_quad_test.sv
// Top level: pipelined even-odd point-in-quadrilateral test.
// Usage:
//   Drive corners A..D and the test point on the in_ ports and pulse start.
//   A transaction is taken at every rising edge where start is high and busy
//   is low; busy stays low, so a new query may enter every cycle.
//   Each transaction yields one result: out_inside_res is valid for exactly
//   one cycle while out_strobe is high.
// Pipeline: differences are registered at the accepting edge, then products,
//   compares and the output register follow.
//   Throughput: one transaction per cycle.
// The bounding-box check runs beside the edge units in the same stages.
// Reset (rst_n low, synchronous) clears all valid bits, so no result
//   strobes until new transactions arrive; payload registers are not reset.
// The receiver cannot stall: out_strobe is a one-cycle strobe and the
//   pipeline never holds.
`default_nettype none
module point_in_quad_test (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire piq_pkg::coord_t in_ax,
  input  wire piq_pkg::coord_t in_ay,
  input  wire piq_pkg::coord_t in_bx,
  input  wire piq_pkg::coord_t in_by_coord,
  input  wire piq_pkg::coord_t in_cx,
  input  wire piq_pkg::coord_t in_cy,
  input  wire piq_pkg::coord_t in_dx,
  input  wire piq_pkg::coord_t in_dy,
  input  wire piq_pkg::coord_t in_px,
  input  wire piq_pkg::coord_t in_py,
  output logic                 out_strobe,
  output logic                 out_inside_res
);

  logic accept;
  logic [2:0] vld_r, vld_nxt;
  logic out_strobe_r, out_inside_r, out_inside_nxt;

  piq_pkg::coord_t minx_r, maxx_r, miny_r, maxy_r, sx_r, sy_r;
  piq_pkg::coord_t minx_nxt, maxx_nxt, miny_nxt, maxy_nxt;
  piq_pkg::coord_t mx0, mx1, Mx0, Mx1, my0, my1, My0, My1;
  logic in_box2_r, in_box2_nxt, in_box3_r;

  logic [piq_pkg::NUM_EDGES-1:0] toggles;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // bounding box: two-level min/max tree
  always_comb begin
    mx0 = (in_ax < in_bx) ? in_ax : in_bx;
    mx1 = (in_cx < in_dx) ? in_cx : in_dx;
    Mx0 = (in_ax > in_bx) ? in_ax : in_bx;
    Mx1 = (in_cx > in_dx) ? in_cx : in_dx;
    my0 = (in_ay < in_by_coord) ? in_ay : in_by_coord;
    my1 = (in_cy < in_dy) ? in_cy : in_dy;
    My0 = (in_ay > in_by_coord) ? in_ay : in_by_coord;
    My1 = (in_cy > in_dy) ? in_cy : in_dy;
    minx_nxt = (mx0 < mx1) ? mx0 : mx1;
    maxx_nxt = (Mx0 > Mx1) ? Mx0 : Mx1;
    miny_nxt = (my0 < my1) ? my0 : my1;
    maxy_nxt = (My0 > My1) ? My0 : My1;
  end

  always_comb begin
    in_box2_nxt = !((sx_r < minx_r) || (sx_r > maxx_r) ||
                    (sy_r < miny_r) || (sy_r > maxy_r));
  end

  // edges in ray-cast order: (A,D) (B,A) (C,B) (D,C)
  piq_edge_unit u_edge0 (
    .clk(clk), .xi(in_ax), .yi(in_ay), .xj(in_dx), .yj(in_dy),
    .sx(in_px), .sy(in_py), .toggle(toggles[0])
  );
  piq_edge_unit u_edge1 (
    .clk(clk), .xi(in_bx), .yi(in_by_coord), .xj(in_ax), .yj(in_ay),
    .sx(in_px), .sy(in_py), .toggle(toggles[1])
  );
  piq_edge_unit u_edge2 (
    .clk(clk), .xi(in_cx), .yi(in_cy), .xj(in_bx), .yj(in_by_coord),
    .sx(in_px), .sy(in_py), .toggle(toggles[2])
  );
  piq_edge_unit u_edge3 (
    .clk(clk), .xi(in_dx), .yi(in_dy), .xj(in_cx), .yj(in_cy),
    .sx(in_px), .sy(in_py), .toggle(toggles[3])
  );

  always_comb begin
    out_inside_nxt = in_box3_r && (^toggles);
    vld_nxt = {vld_r[1:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= vld_nxt;
      out_strobe_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    minx_r       <= minx_nxt;
    maxx_r       <= maxx_nxt;
    miny_r       <= miny_nxt;
    maxy_r       <= maxy_nxt;
    sx_r         <= in_px;
    sy_r         <= in_py;
    in_box2_r    <= in_box2_nxt;
    in_box3_r    <= in_box2_r;
    out_inside_r <= out_inside_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_inside_res = out_inside_r;

endmodule
`default_nettype wire

>>> design/piq_edge_unit.sv
// Three-stage crossing test for one edge of the quadrilateral.
`default_nettype none
module piq_edge_unit (
  input  wire logic            clk,
  input  wire piq_pkg::coord_t xi,
  input  wire piq_pkg::coord_t yi,
  input  wire piq_pkg::coord_t xj,
  input  wire piq_pkg::coord_t yj,
  input  wire piq_pkg::coord_t sx,
  input  wire piq_pkg::coord_t sy,
  output logic                 toggle
);

  // stage 1: differences and straddle
  piq_pkg::diff_t dy_r, ex_r, ey_r, ox_r;
  piq_pkg::diff_t dy_nxt, ex_nxt, ey_nxt, ox_nxt;
  logic           straddle1_r, straddle1_nxt;

  // stage 2: products
  piq_pkg::prod_t p1_r, p2_r, p1_nxt, p2_nxt;
  logic           straddle2_r, dy_pos_r, dy_pos_nxt;

  // stage 3: crossing flag
  logic           toggle_r, toggle_nxt;

  always_comb begin
    dy_nxt = piq_pkg::DIFF_W'(yj) - piq_pkg::DIFF_W'(yi);
    ex_nxt = piq_pkg::DIFF_W'(xj) - piq_pkg::DIFF_W'(xi);
    ey_nxt = piq_pkg::DIFF_W'(sy) - piq_pkg::DIFF_W'(yi);
    ox_nxt = piq_pkg::DIFF_W'(sx) - piq_pkg::DIFF_W'(xi);
    straddle1_nxt = (yi > sy) != (yj > sy);
  end

  always_comb begin
    p1_nxt = piq_pkg::PROD_W'(ox_r) * piq_pkg::PROD_W'(dy_r);
    p2_nxt = piq_pkg::PROD_W'(ex_r) * piq_pkg::PROD_W'(ey_r);
    dy_pos_nxt = ~dy_r[piq_pkg::DIFF_W-1];
  end

  // ox < ex*ey/dy, multiplied through by dy; flip the compare for negative dy
  always_comb begin
    if (dy_pos_r) begin
      toggle_nxt = straddle2_r && (p1_r < p2_r);
    end else begin
      toggle_nxt = straddle2_r && (p2_r < p1_r);
    end
  end

  always_ff @(posedge clk) begin
    dy_r        <= dy_nxt;
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    ox_r        <= ox_nxt;
    straddle1_r <= straddle1_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    dy_pos_r    <= dy_pos_nxt;
    straddle2_r <= straddle1_r;
    toggle_r    <= toggle_nxt;
  end

  assign toggle = toggle_r;

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the pipelined point-in-quadrilateral test.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    piq_pkg::coord_t ax, ay, bx, by_c, cx, cy, dx, dy, px, py;
    bit              drain;  // hold this query until every pending result is back
  } quad_query_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  piq_pkg::coord_t in_ax = '0, in_ay = '0, in_bx = '0, in_by_coord = '0, in_cx = '0;
  piq_pkg::coord_t in_cy = '0, in_dx = '0, in_dy = '0, in_px = '0, in_py = '0;
  logic   out_strobe;
  logic   out_inside_res;

  quad_query_t query_q[$];
  bit          inside_q[$];
  quad_query_t cur_query;
  int          gap_left = 0;
  int          burst_left = 8;
  int          error_count = 0;
  int          checked_count = 0;
  int          inside_count = 0;
  int          drain_count = 0;
  int          settle;

  point_in_quad_test DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_ax         (in_ax),
    .in_ay         (in_ay),
    .in_bx         (in_bx),
    .in_by_coord   (in_by_coord),
    .in_cx         (in_cx),
    .in_cy         (in_cy),
    .in_dx         (in_dx),
    .in_dy         (in_dy),
    .in_px         (in_px),
    .in_py         (in_py),
    .out_strobe    (out_strobe),
    .out_inside_res(out_inside_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Even-odd ray casting toward +x, crossings compared by exact products.
  function automatic bit point_inside(input quad_query_t q);
    longint xs[4], ys[4];
    longint sx, sy, min_x, max_x, min_y, max_y;
    longint edge_dy, edge_dx, rel_y, rel_x;
    bit     hit, left;
    int     i, j;
    xs[0] = q.ax; ys[0] = q.ay;
    xs[1] = q.bx; ys[1] = q.by_c;
    xs[2] = q.cx; ys[2] = q.cy;
    xs[3] = q.dx; ys[3] = q.dy;
    sx = q.px;
    sy = q.py;
    min_x = xs[0]; max_x = xs[0];
    min_y = ys[0]; max_y = ys[0];
    for (i = 1; i < 4; i++) begin
      if (xs[i] < min_x) min_x = xs[i];
      if (xs[i] > max_x) max_x = xs[i];
      if (ys[i] < min_y) min_y = ys[i];
      if (ys[i] > max_y) max_y = ys[i];
    end
    hit = 1'b0;
    if (sx < min_x || sx > max_x || sy < min_y || sy > max_y) return 1'b0;
    for (i = 0; i < 4; i++) begin
      j = (i + 3) % 4;
      if ((ys[i] > sy) != (ys[j] > sy)) begin
        edge_dy = ys[j] - ys[i];
        edge_dx = xs[j] - xs[i];
        rel_y   = sy - ys[i];
        rel_x   = sx - xs[i];
        // multiply through by edge_dy; flip the compare when it is negative
        if (edge_dy > 0) left = (rel_x * edge_dy) < (edge_dx * rel_y);
        else             left = (edge_dx * rel_y) < (rel_x * edge_dy);
        if (left) hit = !hit;
      end
    end
    return hit;
  endfunction

  task automatic add_query(input int ax, ay, bx, by_c, cx, cy, dx, dy, px, py,
                           input bit drain);
    quad_query_t q;
    q.ax = piq_pkg::coord_t'(ax);   q.ay = piq_pkg::coord_t'(ay);
    q.bx = piq_pkg::coord_t'(bx);   q.by_c = piq_pkg::coord_t'(by_c);
    q.cx = piq_pkg::coord_t'(cx);   q.cy = piq_pkg::coord_t'(cy);
    q.dx = piq_pkg::coord_t'(dx);   q.dy = piq_pkg::coord_t'(dy);
    q.px = piq_pkg::coord_t'(px);   q.py = piq_pkg::coord_t'(py);
    q.drain = drain;
    query_q.insert(query_q.size(), q);
  endtask

  function automatic int pick_between(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  task automatic add_random_query(input bit drain);
    int vx[4], vy[4];
    int px, py, mode, span, mid_x, mid_y, lo_x, hi_x, lo_y, hi_y, k;
    mode = $urandom_range(9);
    span = 1 << $urandom_range(15, 2);
    mid_x = pick_between(-32768, 32767);
    mid_y = pick_between(-32768, 32767);
    for (k = 0; k < 4; k++) begin
      case (mode)
        0, 1: begin
          vx[k] = int'(piq_pkg::coord_t'($urandom));
          vy[k] = int'(piq_pkg::coord_t'($urandom));
        end
        6: begin
          vx[k] = pick_between(-4, 4);
          vy[k] = pick_between(-4, 4);
        end
        7: begin
          vx[k] = pick_extreme();
          vy[k] = pick_extreme();
        end
        default: begin
          vx[k] = clamp_coord(mid_x + pick_between(-span, span));
          vy[k] = clamp_coord(mid_y + pick_between(-span, span));
        end
      endcase
    end
    if (mode == 9) begin
      // axis-aligned rectangle: two horizontal edges
      vx[1] = vx[0]; vy[1] = vy[2];
      vx[3] = vx[2]; vy[3] = vy[0];
    end
    lo_x = vx[0]; hi_x = vx[0]; lo_y = vy[0]; hi_y = vy[0];
    for (k = 1; k < 4; k++) begin
      if (vx[k] < lo_x) lo_x = vx[k];
      if (vx[k] > hi_x) hi_x = vx[k];
      if (vy[k] < lo_y) lo_y = vy[k];
      if (vy[k] > hi_y) hi_y = vy[k];
    end
    k = $urandom_range(3);
    if (mode == 8) begin
      // land on a vertex or on an edge midpoint
      if ($urandom_range(1) == 0) begin
        px = vx[k]; py = vy[k];
      end else begin
        px = (vx[k] + vx[(k + 1) % 4]) >>> 1;
        py = (vy[k] + vy[(k + 1) % 4]) >>> 1;
      end
    end else if (mode == 7 && $urandom_range(1) == 0) begin
      px = pick_extreme(); py = pick_extreme();
    end else if (mode == 9 && $urandom_range(2) == 0) begin
      px = ($urandom_range(1) == 0) ? lo_x : hi_x;
      py = pick_between(lo_y, hi_y);
    end else if ($urandom_range(19) < 17) begin
      px = pick_between(lo_x, hi_x);
      py = pick_between(lo_y, hi_y);
    end else begin
      px = int'(piq_pkg::coord_t'($urandom));
      py = int'(piq_pkg::coord_t'($urandom));
    end
    add_query(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], vx[3], vy[3], px, py, drain);
  endtask

  // Driver: bursts of back-to-back transactions with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) inside_q.insert(inside_q.size(), point_inside(cur_query));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (query_q.size() != 0 && !(query_q[0].drain && inside_q.size() != 0)) begin
          cur_query = query_q.pop_front();
          if (cur_query.drain) drain_count++;
          in_ax <= cur_query.ax;  in_ay <= cur_query.ay;
          in_bx <= cur_query.bx;  in_by_coord <= cur_query.by_c;
          in_cx <= cur_query.cx;  in_cy <= cur_query.cy;
          in_dx <= cur_query.dx;  in_dy <= cur_query.dy;
          in_px <= cur_query.px;  in_py <= cur_query.py;
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(3);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(64, 24) : $urandom_range(12, 1);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (inside_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual inside_res=%b",
                 $time, out_inside_res);
        error_count++;
      end else begin
        bit exp_inside;
        exp_inside = inside_q.pop_front();
        checked_count++;
        if (exp_inside) inside_count++;
        if (out_inside_res !== exp_inside) begin
          $display("%0t: inside_res mismatch, expected %b, actual %b",
                   $time, exp_inside, out_inside_res);
          error_count++;
        end
      end
    end
  end

  initial begin
    // square of side 10.0 in Q11.4, interior, outside, borders and corners
    add_query(0, 0, 160, 0, 160, 160, 0, 160, 80, 80, 1'b0);
    add_query(0, 0, 160, 0, 160, 160, 0, 160, 200, 80, 1'b0);
    add_query(0, 0, 160, 0, 160, 160, 0, 160, 0, 80, 1'b0);
    add_query(0, 0, 160, 0, 160, 160, 0, 160, 160, 80, 1'b0);
    add_query(0, 0, 160, 0, 160, 160, 0, 160, 80, 0, 1'b0);
    add_query(0, 0, 160, 0, 160, 160, 0, 160, 80, 160, 1'b0);
    add_query(0, 0, 160, 0, 160, 160, 0, 160, 0, 0, 1'b0);
    add_query(0, 0, 160, 0, 160, 160, 0, 160, 160, 160, 1'b0);
    // diamond: inside the box but outside the shape, then inside
    add_query(0, -100, 100, 0, 0, 100, -100, 0, 60, 60, 1'b0);
    add_query(0, -100, 100, 0, 0, 100, -100, 0, 10, 10, 1'b0);
    // self-intersecting bowtie
    add_query(0, 0, 100, 100, 100, 0, 0, 100, 50, 20, 1'b0);
    add_query(0, 0, 100, 100, 100, 0, 0, 100, 20, 50, 1'b0);
    // collapsed quads: single point and a line
    add_query(5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 1'b0);
    add_query(-10, -10, 0, 0, 10, 10, 20, 20, 5, 5, 1'b0);
    // point on a slanted edge
    add_query(0, 0, 100, 50, 0, 100, -20, 50, 50, 25, 1'b0);
    // full-range coordinates
    add_query(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767, 0, 0, 1'b0);
    add_query(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
              -32768, -32768, 1'b0);
    add_query(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
              32767, 32767, 1'b0);
    add_query(-32768, 0, 0, -32768, 32767, 0, 0, 32767, -1, -1, 1'b0);
    add_query(-32768, 0, 0, -32768, 32767, 0, 0, 32767, 32767, 32767, 1'b0);
    add_query(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, 100, -5, 1'b0);
    add_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b0);
    for (int n = 0; n < 450; n++) add_random_query(n % 150 == 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (query_q.size() != 0 || start) @(posedge clk);
    settle = 0;
    while (inside_q.size() != 0 && settle < 50) begin
      @(posedge clk);
      settle++;
    end
    repeat (8) @(posedge clk);
    if (inside_q.size() != 0) begin
      $display("%0t: %0d results never arrived, expected %0d more, actual 0",
               $time, inside_q.size(), inside_q.size());
      error_count++;
    end
    $display("Checked %0d hit tests (%0d inside, %0d outside), %0d drain pauses,",
             checked_count, inside_count, checked_count - inside_count, drain_count);
    $display("over border, corner, degenerate, bowtie and full-range quads plus random shapes.");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
design/piq_pkg.sv
design/piq_edge_unit.sv
design/point_in_quad_test.sv
tb/tb.sv
